FILE: rtl/core/heap_sorter_unit_defines.svh
// Assertion macros used by the port-level checker of the heap sorter.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef HEAP_SORTER_UNIT_DEFINES_SVH
`define HEAP_SORTER_UNIT_DEFINES_SVH

// Reports an error when the implication fails; it is not checked while reset is low.
`define HSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap sorter check failed");

// Reports an error when the next-cycle implication fails; it is not checked while reset is low.
`define HSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap sorter check failed");

`endif

FILE: rtl/core/hsort_pkg.sv
// Package of the heap sorter: controller command and status types, and fixed widths.
// It has no dependencies.
`timescale 1ns / 1ps
package hsort_pkg;
    localparam int DATA_W = 32;

    typedef struct packed {
        logic load;      // write the input beat into the store
        logic sel_b;     // read the store at child address instead of node address
        logic cap_a;     // load register A from the read data
        logic cap_b;     // load register B from the read data
        logic wr_a;      // write register B into the node
        logic wr_b;      // write register A into the child
    } t_cmd;
endpackage

FILE: rtl/core/hsort_datapath.sv
// Datapath of the heap sorter: the element store with one read and one write port.
// It depends on hsort_pkg.
`timescale 1ns / 1ps
module hsort_datapath #(
    parameter int AW = 6
) (
    input  logic                    i_clk,
    input  hsort_pkg::t_cmd         i_cmd,
    input  logic [AW-1:0]           i_addr_a,
    input  logic [AW-1:0]           i_addr_b,
    input  logic [AW-1:0]           i_addr_load,
    input  logic [31:0]             i_value,
    input  logic                    i_desc,
    output logic [31:0]             o_rd_data,
    output logic                    o_b_above,
    output logic                    o_rd_above
);
    import hsort_pkg::*;

    logic [DATA_W-1:0] r_mem [2**AW];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [AW-1:0]     n_wr_addr;
    logic [DATA_W-1:0] n_wr_data;
    logic              n_wr_en;
    logic [AW-1:0]     n_rd_addr;

    always_comb begin
        n_wr_en   = i_cmd.load | i_cmd.wr_a | i_cmd.wr_b;
        n_wr_addr = i_addr_load;
        n_wr_data = i_value;
        if (i_cmd.wr_a) begin
            n_wr_addr = i_addr_a;
            n_wr_data = r_b;
        end else if (i_cmd.wr_b) begin
            n_wr_addr = i_addr_b;
            n_wr_data = r_a;
        end
        n_rd_addr = i_cmd.sel_b ? i_addr_b : i_addr_a;
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
        r_rd_data <= r_mem[n_rd_addr];
    end

    // Register A holds the node value, register B the best child.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_a <= r_rd_data;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_rd_data;
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_b_above  = i_desc ? ($signed(r_b) < $signed(r_a))
                               : ($signed(r_b) > $signed(r_a));
    assign o_rd_above = i_desc ? ($signed(r_rd_data) < $signed(r_b))
                               : ($signed(r_rd_data) > $signed(r_b));
endmodule

FILE: rtl/core/hsort_ctrl.sv
// Controller of the heap sorter: load, heap build, extraction and output sequencing.
// It depends on hsort_pkg and drives hsort_datapath through t_cmd.
`timescale 1ns / 1ps
module hsort_ctrl #(
    parameter int AW = 6,
    parameter int CW = 7,
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_last_in,
    input  logic              i_stall_out,
    output logic              o_valid,
    output logic              o_last_out,
    output logic              o_overflowed,
    input  logic              i_cfg_desc,
    output logic              o_desc,
    input  logic              i_b_above,
    input  logic              i_rd_above,
    output hsort_pkg::t_cmd   o_cmd,
    output logic [AW-1:0]     o_addr_a,
    output logic [AW-1:0]     o_addr_b,
    output logic [AW-1:0]     o_addr_load,
    output logic              o_capture
);
    import hsort_pkg::*;

    localparam logic [4:0] S_LOAD   = 5'd0;
    localparam logic [4:0] S_BUILD  = 5'd1;
    localparam logic [4:0] S_SIFT   = 5'd2;
    localparam logic [4:0] S_RDL    = 5'd3;
    localparam logic [4:0] S_CMPL   = 5'd4;
    localparam logic [4:0] S_RDR    = 5'd5;
    localparam logic [4:0] S_CMPR   = 5'd6;
    localparam logic [4:0] S_DEC    = 5'd7;
    localparam logic [4:0] S_SWPB   = 5'd8;
    localparam logic [4:0] S_EXTR   = 5'd9;
    localparam logic [4:0] S_XRD0   = 5'd10;
    localparam logic [4:0] S_XRDE   = 5'd11;
    localparam logic [4:0] S_XCAP   = 5'd12;
    localparam logic [4:0] S_XWA    = 5'd13;
    localparam logic [4:0] S_XWB    = 5'd14;
    localparam logic [4:0] S_ORD    = 5'd15;
    localparam logic [4:0] S_OCAP   = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_size, n_size;
    logic [CW-1:0] r_par, n_par;
    logic [CW-1:0] r_node, n_node;
    logic [CW-1:0] r_child, n_child;
    logic        r_drop, n_drop;
    logic        r_desc, n_desc;
    logic        r_extract, n_extract;
    logic        r_valid, n_valid;
    logic        r_last, n_last;
    logic [CW:0] w_left;
    logic [CW:0] w_right;
    t_cmd        w_cmd;
    logic        w_cap;

    assign w_left  = {r_node, 1'b1};
    assign w_right = {1'b0, r_child} + 1'b1;

    always_comb begin
        n_state = r_state; n_count = r_count; n_size = r_size; n_par = r_par;
        n_node = r_node; n_child = r_child; n_drop = r_drop;
        n_desc = r_desc; n_extract = r_extract; n_valid = r_valid; n_last = r_last;
        w_cmd = '0;
        w_cap = 1'b0;
        if (r_valid && !i_stall_out) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    if (r_count < CW'(CAPACITY)) begin
                        w_cmd.load = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_in) begin
                        n_size = n_count;
                        n_par = n_count >> 1;
                        n_desc = i_cfg_desc;
                        n_extract = 1'b0;
                        n_state = S_BUILD;
                    end
                end
            end
            S_BUILD: begin
                if (r_par == '0) begin
                    n_state = S_EXTR;
                end else begin
                    n_par = r_par - 1'b1;
                    n_node = r_par - 1'b1;
                    n_extract = 1'b0;
                    n_state = S_SIFT;
                end
            end
            S_SIFT: begin
                if (w_left < {1'b0, r_size}) begin
                    n_child = w_left[CW-1:0];
                    n_state = S_RDL;
                end else begin
                    n_state = r_extract ? S_EXTR : S_BUILD;
                end
            end
            S_RDL: begin
                w_cmd.cap_a = 1'b1;
                w_cmd.sel_b = 1'b1;
                n_state = S_CMPL;
            end
            S_CMPL: begin
                w_cmd.cap_b = 1'b1;
                if (w_right < {1'b0, r_size}) begin
                    n_child = w_right[CW-1:0];
                    n_state = S_RDR;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_RDR: begin
                w_cmd.sel_b = 1'b1;
                n_state = S_CMPR;
            end
            S_CMPR: begin
                if (i_rd_above) begin
                    w_cmd.cap_b = 1'b1;
                end else begin
                    n_child = r_child - 1'b1;
                end
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_b_above) begin
                    w_cmd.wr_a = 1'b1;
                    n_state = S_SWPB;
                end else begin
                    n_state = r_extract ? S_EXTR : S_BUILD;
                end
            end
            S_SWPB: begin
                w_cmd.wr_b = 1'b1;
                n_node = r_child;
                n_state = S_SIFT;
            end
            S_EXTR: begin
                n_node = '0;
                if (r_size > 1'b1) begin
                    n_child = r_size - 1'b1;
                    n_state = S_XRD0;
                end else begin
                    n_state = S_ORD;
                end
            end
            S_XRD0: begin
                n_state = S_XRDE;
            end
            S_XRDE: begin
                w_cmd.cap_a = 1'b1;
                w_cmd.sel_b = 1'b1;
                n_state = S_XCAP;
            end
            S_XCAP: begin
                w_cmd.cap_b = 1'b1;
                n_state = S_XWA;
            end
            S_XWA: begin
                w_cmd.wr_a = 1'b1;
                n_state = S_XWB;
            end
            S_XWB: begin
                w_cmd.wr_b = 1'b1;
                n_size = r_size - 1'b1;
                n_extract = 1'b1;
                n_state = S_SIFT;
            end
            S_ORD: begin
                n_state = S_OCAP;
            end
            S_OCAP: begin
                w_cap = 1'b1;
                n_valid = 1'b1;
                n_last = (r_node + 1'b1 == r_count);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (r_valid && !i_stall_out) begin
                    if (r_last) begin
                        n_count = '0;
                        n_drop = 1'b0;
                        n_last = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_node = r_node + 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_cmd = w_cmd;
    assign o_addr_a = r_node[AW-1:0];
    assign o_addr_b = r_child[AW-1:0];
    assign o_addr_load = r_count[AW-1:0];
    assign o_capture = w_cap;
    assign o_stall = (r_state != S_LOAD);
    assign o_valid = r_valid;
    assign o_last_out = r_last;
    assign o_overflowed = r_drop;
    assign o_desc = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_count <= '0; r_drop <= 1'b0; r_valid <= 1'b0;
            r_desc <= 1'b0; r_extract <= 1'b0; r_last <= 1'b0;
            r_size <= '0; r_par <= '0; r_node <= '0; r_child <= '0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_drop <= n_drop;
            r_valid <= n_valid; r_desc <= n_desc; r_extract <= n_extract;
            r_last <= n_last;
            r_size <= n_size; r_par <= n_par; r_node <= n_node; r_child <= n_child;
        end
    end
endmodule

FILE: rtl/core/heap_sorter_unit.sv
// Channel     Direction  Signals
// input       in         i_valid, o_stall, i_value, i_last_in
// output      out        o_valid, i_stall, o_sorted_value, o_last_out, o_overflowed
// config      in         i_cfg_we, i_cfg_wdata
// A set loads at one beat per cycle. After the last beat the store is heap sorted with
// one store access per cycle, set by the single store port: a sift level runs SIFT, RDL,
// CMPL, RDR, CMPR, DEC and SWPB, a root swap EXTR, XRD0, XRDE, XCAP, XWA and XWB. Results
// leave one at a time, each held until taken; input stalls until the set is out. Reset is
// synchronous and active low; it clears the count, flag, config bit and control state.
`timescale 1ns / 1ps
module heap_sorter_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_value,
    input  logic                 i_last_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_sorted_value,
    output logic                 o_last_out,
    output logic                 o_overflowed,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata
);
    import hsort_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic          r_cfg_desc;
    t_cmd          w_cmd;
    logic [AW-1:0] w_addr_a, w_addr_b, w_addr_load;
    logic [31:0]   w_rd;
    logic          w_b_above, w_rd_above, w_desc, w_cap;
    logic [31:0]   r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_desc <= 1'b0;
        end else if (i_cfg_we) begin
            r_cfg_desc <= i_cfg_wdata;
        end
    end

    hsort_ctrl #(.AW(AW), .CW(CW), .CAPACITY(CAPACITY)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_last_in(i_last_in), .i_stall_out(i_stall), .o_valid(o_valid),
        .o_last_out(o_last_out), .o_overflowed(o_overflowed),
        .i_cfg_desc(r_cfg_desc), .o_desc(w_desc), .i_b_above(w_b_above),
        .i_rd_above(w_rd_above),
        .o_cmd(w_cmd), .o_addr_a(w_addr_a), .o_addr_b(w_addr_b),
        .o_addr_load(w_addr_load), .o_capture(w_cap)
    );

    hsort_datapath #(.AW(AW)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_addr_a(w_addr_a), .i_addr_b(w_addr_b),
        .i_addr_load(w_addr_load), .i_value(i_value), .i_desc(w_desc),
        .o_rd_data(w_rd), .o_b_above(w_b_above), .o_rd_above(w_rd_above)
    );

    always_ff @(posedge i_clk) begin
        if (w_cap) begin
            r_out <= w_rd;
        end
    end
    assign o_sorted_value = r_out;
endmodule

FILE: rtl/core/heap_sorter_unit_checker.sv
// Port-level checker of the heap sorter, bound to the top level.
// It depends on heap_sorter_unit_defines.svh.
`timescale 1ns / 1ps
`include "heap_sorter_unit_defines.svh"
module heap_sorter_unit_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_sorted_value,
    input logic        o_last_out
);
    `HSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_sorted_value))
    `HSU_ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, o_valid, o_stall)
    `HSU_ASSERT_NEXT(a_last_frees, i_clk, i_rst_n, o_valid && o_last_out && !i_stall, !o_valid)
endmodule

bind heap_sorter_unit heap_sorter_unit_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_sorted_value(o_sorted_value),
    .o_last_out(o_last_out)
);
